FILE: hdl/rbdq_pkg.sv
// Shared types, codes and sizes for the ring buffer deque.
package rbdq_pkg;

    // Store geometry
    localparam int DEPTH     = 16;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CAP_W     = 5;
    localparam int DATA_BITS = 32;

    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(DEPTH);
    localparam logic [CAP_W-1:0] CAP_MIN = CAP_W'(1);

    // Operation codes; codes above OP_QUERY behave as a query
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_QUERY      = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_EMPTY      = 2'd2;

    typedef logic signed [DATA_BITS-1:0] t_data;
    typedef logic [IDX_W-1:0]            t_idx;
    typedef logic [CAP_W-1:0]            t_cap;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] data_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] popped_value;
        logic signed [31:0] front_value;
        logic signed [31:0] rear_value;
        logic               full_flag;
        logic               empty_flag;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic fetch;
        logic cfg_write;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_fetch;
    } t_stat;

endpackage

FILE: hdl/ring_buffer_deque_unit.sv
// Ring buffer deque: top level joining the controller and the datapath.
//
// Input channel (i_in_valid / o_in_stall) carries one item: an operation
// (push front, push back, pop front, pop back, query) and a data word.
// Output channel (o_out_valid / i_out_stall) returns one result item per
// input item: status, popped value, front and rear entries, full and empty.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes the capacity,
// saturated to 1..16; every write empties the deque. Ready is high while idle.
// Sequence: an accepted input item passes the execute state and, for a pop
// that leaves entries behind, a fetch state before the result item is offered,
// since the new end entry is read from the single registered read port of the
// entry store. One item is in flight at a time and the input reopens in the
// cycle after the result is taken.
// While the receiver stalls, the result item is held unchanged and no new
// item is accepted. Reset empties the deque and sets the capacity to 16; the
// entry store itself is not cleared, entries are only read after a write.
module ring_buffer_deque_unit
    import rbdq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  t_cap      i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    rbdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rbdq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_out_item (o_out_item)
    );

endmodule

FILE: hdl/rbdq_ctrl.sv
// Sequencing state machine for the ring buffer deque.
module rbdq_ctrl
    import rbdq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  logic  i_cfg_valid,
    output logic  o_cfg_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_FETCH = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_stat.need_fetch ? S_FETCH : S_OUT;
            end
            S_FETCH: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Handshakes and datapath commands
    assign o_in_stall       = (r_state != S_IDLE);
    assign o_cfg_ready      = (r_state == S_IDLE);
    assign o_out_valid      = (r_state == S_OUT);
    assign o_cmd.capture    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec       = (r_state == S_EXEC);
    assign o_cmd.fetch      = (r_state == S_FETCH);
    assign o_cmd.cfg_write  = (r_state == S_IDLE) && i_cfg_valid;

endmodule

FILE: hdl/rbdq_dp.sv
// Datapath: entry store, indices, count, cached end values and result.
module rbdq_dp
    import rbdq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  t_in_item   i_in_item,
    input  t_cap       i_cfg_data,
    output t_stat      o_stat,
    output t_out_item  o_out_item
);

    t_data mem [DEPTH];

    logic [2:0] r_op;
    t_data      r_data;
    t_idx       r_head;
    t_idx       r_tail;
    t_cap       r_count;
    t_cap       r_cap;
    t_data      r_front;
    t_data      r_rear;
    t_data      r_popped;
    logic [1:0] r_status;
    logic       r_fetch_front;
    t_data      r_rd_data;

    logic  is_push;
    logic  is_pop;
    t_idx  head_up;
    t_idx  head_down;
    t_idx  tail_up;
    t_idx  tail_down;
    t_cap  cfg_sat;
    logic  wr_en;
    t_idx  wr_addr;
    t_idx  rd_addr;

    // Circular index steps within the configured capacity
    assign head_up   = ((CAP_W'(r_head) + CAP_W'(1)) >= r_cap) ? '0 : r_head + IDX_W'(1);
    assign tail_up   = ((CAP_W'(r_tail) + CAP_W'(1)) >= r_cap) ? '0 : r_tail + IDX_W'(1);
    assign head_down = (r_head == '0) ? IDX_W'(r_cap - CAP_W'(1)) : r_head - IDX_W'(1);
    assign tail_down = (r_tail == '0) ? IDX_W'(r_cap - CAP_W'(1)) : r_tail - IDX_W'(1);

    assign is_push = (r_op == OP_PUSH_FRONT) || (r_op == OP_PUSH_BACK);
    assign is_pop  = (r_op == OP_POP_FRONT)  || (r_op == OP_POP_BACK);

    // A pop that leaves entries behind must read the new end from the store
    assign o_stat.need_fetch = is_pop && (r_count > CAP_W'(1));

    // Capacity write saturates into 1..DEPTH
    always_comb begin
        cfg_sat = i_cfg_data;
        if (i_cfg_data < CAP_MIN) cfg_sat = CAP_MIN;
        if (i_cfg_data > CAP_MAX) cfg_sat = CAP_MAX;
    end

    // Store write address and read address for this step
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        rd_addr = (r_op == OP_POP_FRONT) ? head_up : tail_down;
        if (i_cmd.exec && is_push && (r_count < r_cap)) begin
            wr_en = 1'b1;
            if (r_count == '0) begin
                wr_addr = '0;
            end else if (r_op == OP_PUSH_FRONT) begin
                wr_addr = head_down;
            end else begin
                wr_addr = tail_up;
            end
        end
    end

    // Entry store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= r_data;
        r_rd_data <= mem[rd_addr];
    end

    // Item capture and fetch side
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_in_item.op;
            r_data <= i_in_item.data_in;
        end
        if (i_cmd.exec) begin
            r_fetch_front <= (r_op == OP_POP_FRONT);
        end
    end

    // Control state: indices, count, capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_cap   <= CAP_MAX;
        end else if (i_cmd.cfg_write) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_cap   <= cfg_sat;
        end else if (i_cmd.exec) begin
            if (is_push && (r_count < r_cap)) begin
                if (r_count == '0) begin
                    r_head <= '0;
                    r_tail <= '0;
                end else if (r_op == OP_PUSH_FRONT) begin
                    r_head <= head_down;
                end else begin
                    r_tail <= tail_up;
                end
                r_count <= r_count + CAP_W'(1);
            end else if (is_pop && (r_count != '0)) begin
                if (r_count == CAP_W'(1)) begin
                    r_head <= '0;
                    r_tail <= '0;
                end else if (r_op == OP_POP_FRONT) begin
                    r_head <= head_up;
                end else begin
                    r_tail <= tail_down;
                end
                r_count <= r_count - CAP_W'(1);
            end
        end
    end

    // Result payload and cached front and rear entries
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= ST_DONE;
            r_popped <= '0;
            if (is_push) begin
                if (r_count >= r_cap) begin
                    r_status <= ST_FULL;
                end else if (r_count == '0) begin
                    r_front <= r_data;
                    r_rear  <= r_data;
                end else if (r_op == OP_PUSH_FRONT) begin
                    r_front <= r_data;
                end else begin
                    r_rear  <= r_data;
                end
            end else if (is_pop) begin
                if (r_count == '0) begin
                    r_status <= ST_EMPTY;
                end else begin
                    r_popped <= (r_op == OP_POP_FRONT) ? r_front : r_rear;
                end
            end
        end else if (i_cmd.fetch) begin
            if (r_fetch_front) begin
                r_front <= r_rd_data;
            end else begin
                r_rear  <= r_rd_data;
            end
        end
    end

    // Result item
    assign o_out_item.status       = r_status;
    assign o_out_item.popped_value = r_popped;
    assign o_out_item.front_value  = (r_count == '0) ? '0 : r_front;
    assign o_out_item.rear_value   = (r_count == '0) ? '0 : r_rear;
    assign o_out_item.full_flag    = (r_count == r_cap);
    assign o_out_item.empty_flag   = (r_count == '0);

endmodule
